/* sv/polyline_area_simplifier_macros.svh */
// Assertion macros shared by the simplifier RTL.
`ifndef POLYLINE_AREA_SIMPLIFIER_MACROS_SVH
`define POLYLINE_AREA_SIMPLIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PAS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pas assertion failed");

// Next-cycle implication, checked outside reset.
`define PAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pas assertion failed");

`endif

/* sv/pas_pkg.sv */
// Shared constants and types for the polyline area simplifier.
package pas_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int TARGET_W        = 7;
  localparam logic [TARGET_W-1:0] MIN_TARGET = 7'd2;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_SIMPLIFY = 1'b1
  } pas_op_t;

  typedef struct packed {
    logic pt;
    logic cost;
    logic stamp;
    logic prev;
    logic next;
  } pas_wen_t;

endpackage

/* sv/pas_in_if.sv */
// Command channel: point loads and simplify requests.
interface pas_in_if #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic                          start_new;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic [pas_pkg::TARGET_W-1:0]  target_count;

  modport source (output valid, opcode, start_new, x_coord, y_coord, target_count,
                  input ready);
  modport sink   (input valid, opcode, start_new, x_coord, y_coord, target_count,
                  output ready);
endinterface

/* sv/pas_out_if.sv */
// Result channel: kept points with the run's largest excluded cost.
interface pas_out_if #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH_DEF
);
  localparam int COST_W = 2 * COORD_WIDTH + 2;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          last_point;
  logic [COST_W-1:0]             max_removed_cost;

  modport source (output valid, out_x, out_y, last_point, max_removed_cost, input ready);
  modport sink   (input valid, out_x, out_y, last_point, max_removed_cost, output ready);
endinterface

/* sv/pas_area.sv */
// Shared doubled-triangle-area unit: one multiplier used for both products.
module pas_area #(
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  output logic                          done,
  output logic [2*COORD_WIDTH+1:0]      cost
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_M1   = 5'b00010,
    A_M2   = 5'b00100,
    A_SUB  = 5'b01000,
    A_DONE = 5'b10000
  } area_state_t;

  area_state_t          state;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod, p1, p2;
  logic signed [PW:0]   diff;

  assign op_a = (state == A_M1) ? dx1 : dy1;
  assign op_b = (state == A_M1) ? dy2 : dx2;
  assign prod = op_a * op_b;
  assign diff = (PW+1)'(p1) - (PW+1)'(p2);
  assign done = (state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            dx1   <= DW'(bx) - DW'(ax);
            dy1   <= DW'(by) - DW'(ay);
            dx2   <= DW'(cx) - DW'(ax);
            dy2   <= DW'(cy) - DW'(ay);
            state <= A_M1;
          end
        end
        A_M1: begin
          p1    <= prod;
          state <= A_M2;
        end
        A_M2: begin
          p2    <= prod;
          state <= A_SUB;
        end
        A_SUB: begin
          cost  <= diff[PW] ? PW'(-diff) : PW'(diff);
          state <= A_DONE;
        end
        A_DONE: state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end
endmodule

/* sv/pas_store.sv */
// Point, cost, stamp and link memories with one shared registered read port.
module pas_store #(
  parameter int MAX_POINTS  = pas_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  pas_pkg::pas_wen_t                    wen,
  input  logic [$clog2(MAX_POINTS)-1:0]        pt_waddr,
  input  logic signed [COORD_WIDTH-1:0]        x_wdata,
  input  logic signed [COORD_WIDTH-1:0]        y_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]        cost_waddr,
  input  logic [2*COORD_WIDTH+1:0]             cost_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]        stamp_waddr,
  input  logic [$clog2(MAX_POINTS+1)-1:0]      stamp_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]        prev_waddr,
  input  logic [$clog2(MAX_POINTS)-1:0]        prev_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]        next_waddr,
  input  logic [$clog2(MAX_POINTS)-1:0]        next_wdata,
  input  logic [$clog2(MAX_POINTS)-1:0]        raddr,
  output logic signed [COORD_WIDTH-1:0]        rd_x,
  output logic signed [COORD_WIDTH-1:0]        rd_y,
  output logic [2*COORD_WIDTH+1:0]             rd_cost,
  output logic [$clog2(MAX_POINTS+1)-1:0]      rd_stamp,
  output logic [$clog2(MAX_POINTS)-1:0]        rd_prev,
  output logic [$clog2(MAX_POINTS)-1:0]        rd_next
);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int COSTW = 2 * COORD_WIDTH + 2;

  logic signed [COORD_WIDTH-1:0] x_mem     [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] y_mem     [MAX_POINTS];
  logic [COSTW-1:0]              cost_mem  [MAX_POINTS];
  logic [CNTW-1:0]               stamp_mem [MAX_POINTS];
  logic [IW-1:0]                 prev_mem  [MAX_POINTS];
  logic [IW-1:0]                 next_mem  [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wen.pt) begin
      x_mem[pt_waddr] <= x_wdata;
      y_mem[pt_waddr] <= y_wdata;
    end
    if (wen.cost) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    if (wen.stamp) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    if (wen.prev) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (wen.next) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_x     <= x_mem[raddr];
    rd_y     <= y_mem[raddr];
    rd_cost  <= cost_mem[raddr];
    rd_stamp <= stamp_mem[raddr];
    rd_prev  <= prev_mem[raddr];
    rd_next  <= next_mem[raddr];
  end
endmodule

/* sv/polyline_area_simplifier.sv */
// Visvalingam-Whyatt polyline simplifier. A load is taken while idle and
// appends a point (start_new begins a new polyline with it); a load without
// start_new is dropped once the store is full. A simplify command holds the
// input off until its last result is taken. After any load it first relinks
// all L points and recomputes every cost. Each removal walks the remaining
// list at one point a cycle, unlinks the point in S_REMOVE, then recomputes
// two costs; a cost takes two passes through the single shared multiplier and
// four reads of the one memory read port. The run ends with a scan for the
// largest excluded cost and an emission pass over every stored point that
// waits for each kept point's result to be taken.
`include "polyline_area_simplifier_macros.svh"

module polyline_area_simplifier #(
  parameter int MAX_POINTS  = pas_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pas_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pas_in_if.sink     pt_in,
  pas_out_if.source  pt_out
);
  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int COSTW = 2 * COORD_WIDTH + 2;
  localparam int TW    = pas_pkg::TARGET_W;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_RB_LINK = 20'h00002,
    S_RB_COST = 20'h00004,
    S_RC0     = 20'h00008,
    S_RC1     = 20'h00010,
    S_RC2     = 20'h00020,
    S_RC3     = 20'h00040,
    S_RC4     = 20'h00080,
    S_RC5     = 20'h00100,
    S_RC6     = 20'h00200,
    S_RC_END  = 20'h00400,
    S_LOOP    = 20'h00800,
    S_SRCH0   = 20'h01000,
    S_SRCH    = 20'h02000,
    S_REMOVE  = 20'h04000,
    S_MAX_RD  = 20'h08000,
    S_MAX_CK  = 20'h10000,
    S_EM_RD   = 20'h20000,
    S_EM_CK   = 20'h40000,
    S_EM_WAIT = 20'h80000
  } state_t;

  state_t                        state;
  logic [CNTW-1:0]               loaded, rem, idx;
  logic                          dirty, rb_mode, nb_pending, have_best;
  logic [TW-1:0]                 k;
  logic [IW-1:0]                 rc_i, n_r, nb_idx, cur, best, best_p, best_n;
  logic [COSTW-1:0]              best_cost, maxc;
  logic signed [COORD_WIDTH-1:0] pax, pay, pbx, pby, pcx, pcy;
  logic signed [COORD_WIDTH-1:0] ox, oy;
  logic                          olast, ovalid;
  logic [COSTW-1:0]              ocost;

  pas_pkg::pas_wen_t             wen;
  logic [IW-1:0]                 pt_waddr, cost_waddr, stamp_waddr;
  logic [IW-1:0]                 prev_waddr, prev_wdata, next_waddr, next_wdata;
  logic [CNTW-1:0]               stamp_wdata, load_idx;
  logic [IW-1:0]                 raddr;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  logic [COSTW-1:0]              rd_cost;
  logic [CNTW-1:0]               rd_stamp;
  logic [IW-1:0]                 rd_prev, rd_next;
  logic                          area_start, area_done;
  logic [COSTW-1:0]              area_cost;
  logic                          in_fire, out_fire, load_ok, rc_end;
  logic [IW-1:0]                 last_idx;

  assign pt_in.ready             = (state == S_IDLE);
  assign in_fire                 = pt_in.valid && pt_in.ready;
  assign pt_out.valid            = ovalid;
  assign pt_out.out_x            = ox;
  assign pt_out.out_y            = oy;
  assign pt_out.last_point       = olast;
  assign pt_out.max_removed_cost = ocost;
  assign out_fire                = ovalid && pt_out.ready;

  assign load_idx   = pt_in.start_new ? '0 : loaded;
  assign load_ok    = pt_in.start_new || (loaded < CNTW'(MAX_POINTS));
  assign last_idx   = IW'(loaded - CNTW'(1));
  assign rc_end     = (rc_i == '0) || (CNTW'(rc_i) + CNTW'(1) >= loaded);
  assign area_start = (state == S_RC5);

  pas_area #(.COORD_WIDTH(COORD_WIDTH)) u_area (
    .clk(clk), .rst(rst), .start(area_start),
    .ax(pax), .ay(pay), .bx(pbx), .by(pby), .cx(pcx), .cy(pcy),
    .done(area_done), .cost(area_cost)
  );

  pas_store #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_store (
    .clk(clk), .wen(wen),
    .pt_waddr(pt_waddr), .x_wdata(pt_in.x_coord), .y_wdata(pt_in.y_coord),
    .cost_waddr(cost_waddr), .cost_wdata(state == S_RC0 ? '0 : area_cost),
    .stamp_waddr(stamp_waddr), .stamp_wdata(stamp_wdata),
    .prev_waddr(prev_waddr), .prev_wdata(prev_wdata),
    .next_waddr(next_waddr), .next_wdata(next_wdata),
    .raddr(raddr),
    .rd_x(rd_x), .rd_y(rd_y), .rd_cost(rd_cost), .rd_stamp(rd_stamp),
    .rd_prev(rd_prev), .rd_next(rd_next)
  );

  always_comb begin
    wen         = '0;
    pt_waddr    = load_idx[IW-1:0];
    cost_waddr  = rc_i;
    stamp_waddr = idx[IW-1:0];
    stamp_wdata = '0;
    prev_waddr  = idx[IW-1:0];
    prev_wdata  = (idx == '0) ? '0 : IW'(idx - CNTW'(1));
    next_waddr  = idx[IW-1:0];
    next_wdata  = (idx + CNTW'(1) < loaded) ? IW'(idx + CNTW'(1)) : idx[IW-1:0];
    raddr       = '0;
    unique case (state)
      S_IDLE: begin
        wen.pt = in_fire && (pt_in.opcode == pas_pkg::OP_LOAD) && load_ok;
      end
      S_RB_LINK: begin
        wen.stamp = (idx != loaded);
        wen.prev  = (idx != loaded);
        wen.next  = (idx != loaded);
      end
      S_RC0: begin
        wen.cost = rc_end;
        raddr    = rc_i;
      end
      S_RC1: raddr = rd_prev;
      S_RC2: raddr = rc_i;
      S_RC3: raddr = n_r;
      S_RC6: wen.cost = area_done;
      S_SRCH0, S_SRCH: raddr = rd_next;
      S_REMOVE: begin
        wen.stamp   = 1'b1;
        wen.prev    = 1'b1;
        wen.next    = 1'b1;
        stamp_waddr = best;
        stamp_wdata = rem;
        next_waddr  = best_p;
        next_wdata  = best_n;
        prev_waddr  = best_n;
        prev_wdata  = best_p;
      end
      S_MAX_RD, S_EM_RD: raddr = idx[IW-1:0];
      S_RB_COST, S_RC4, S_RC5, S_RC_END, S_LOOP, S_MAX_CK, S_EM_CK, S_EM_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      loaded     <= '0;
      rem        <= '0;
      dirty      <= 1'b0;
      ovalid     <= 1'b0;
      rb_mode    <= 1'b0;
      nb_pending <= 1'b0;
      have_best  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (pt_in.opcode == pas_pkg::OP_LOAD) begin
              if (load_ok) begin
                loaded <= load_idx + CNTW'(1);
                dirty  <= 1'b1;
              end
            end else begin
              k   <= (pt_in.target_count < pas_pkg::MIN_TARGET) ? pas_pkg::MIN_TARGET
                                                                : pt_in.target_count;
              idx <= '0;
              state <= dirty ? S_RB_LINK : S_LOOP;
            end
          end
        end
        S_RB_LINK: begin
          if (idx == loaded) begin
            idx   <= '0;
            state <= S_RB_COST;
          end else begin
            idx <= idx + CNTW'(1);
          end
        end
        S_RB_COST: begin
          if (idx == loaded) begin
            rem   <= loaded;
            dirty <= 1'b0;
            state <= S_LOOP;
          end else begin
            rc_i    <= idx[IW-1:0];
            rb_mode <= 1'b1;
            state   <= S_RC0;
          end
        end
        S_RC0: state <= rc_end ? S_RC_END : S_RC1;
        S_RC1: begin
          n_r   <= rd_next;
          state <= S_RC2;
        end
        S_RC2: begin
          pax   <= rd_x;
          pay   <= rd_y;
          state <= S_RC3;
        end
        S_RC3: begin
          pbx   <= rd_x;
          pby   <= rd_y;
          state <= S_RC4;
        end
        S_RC4: begin
          pcx   <= rd_x;
          pcy   <= rd_y;
          state <= S_RC5;
        end
        S_RC5: state <= S_RC6;
        S_RC6: begin
          if (area_done) begin
            state <= S_RC_END;
          end
        end
        S_RC_END: begin
          priority if (rb_mode) begin
            idx   <= idx + CNTW'(1);
            state <= S_RB_COST;
          end else if (nb_pending) begin
            nb_pending <= 1'b0;
            rc_i       <= nb_idx;
            state      <= S_RC0;
          end else begin
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if ((TW'(rem) > k) && (loaded >= CNTW'(3))) begin
            state <= S_SRCH0;
          end else begin
            idx   <= '0;
            maxc  <= '0;
            state <= S_MAX_RD;
          end
        end
        S_SRCH0: begin
          cur       <= rd_next;
          have_best <= 1'b0;
          state     <= S_SRCH;
        end
        S_SRCH: begin
          if (cur == last_idx) begin
            if (have_best) begin
              state <= S_REMOVE;
            end else begin
              idx   <= '0;
              maxc  <= '0;
              state <= S_MAX_RD;
            end
          end else begin
            if (!have_best || (best_cost > rd_cost)) begin
              best      <= cur;
              best_cost <= rd_cost;
              best_p    <= rd_prev;
              best_n    <= rd_next;
              have_best <= 1'b1;
            end
            cur <= rd_next;
          end
        end
        S_REMOVE: begin
          rem        <= rem - CNTW'(1);
          rc_i       <= best_p;
          nb_idx     <= best_n;
          nb_pending <= 1'b1;
          rb_mode    <= 1'b0;
          state      <= S_RC0;
        end
        S_MAX_RD: begin
          if (idx == loaded) begin
            idx   <= '0;
            state <= S_EM_RD;
          end else begin
            state <= S_MAX_CK;
          end
        end
        S_MAX_CK: begin
          if ((TW'(rd_stamp) > k) && (rd_cost > maxc)) begin
            maxc <= rd_cost;
          end
          idx   <= idx + CNTW'(1);
          state <= S_MAX_RD;
        end
        S_EM_RD: state <= (idx == loaded) ? S_IDLE : S_EM_CK;
        S_EM_CK: begin
          if (TW'(rd_stamp) <= k) begin
            ox     <= rd_x;
            oy     <= rd_y;
            olast  <= (idx + CNTW'(1) == loaded);
            ocost  <= maxc;
            ovalid <= 1'b1;
            state  <= S_EM_WAIT;
          end else begin
            idx   <= idx + CNTW'(1);
            state <= S_EM_RD;
          end
        end
        S_EM_WAIT: begin
          if (out_fire) begin
            ovalid <= 1'b0;
            idx    <= idx + CNTW'(1);
            state  <= S_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PAS_ASSERT_NOW(a_rem_bound, clk, rst, !dirty, rem <= loaded)
  `PAS_ASSERT_NOW(a_out_only_wait, clk, rst, ovalid, state == S_EM_WAIT)
  `PAS_ASSERT_NOW(a_remove_has_best, clk, rst, state == S_REMOVE, have_best)
  `PAS_ASSERT_NEXT(a_last_ends, clk, rst, out_fire && olast, idx == loaded)
endmodule

/* tb/sv/polyline_area_simplifier_tb.sv */
// Self-checking testbench for the polyline area simplifier with a built-in simplification predictor.
module polyline_area_simplifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int CW = 16;
  localparam int KW = 2 * CW + 2;
  localparam int TW = pas_pkg::TARGET_W;
  localparam int STALL_LIMIT = 100000;

  typedef struct {
    pas_pkg::pas_op_t op;
    logic sn;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [TW-1:0] tgt;
    bit drain;
  } cmd_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic last;
    logic [KW-1:0] cost;
  } kept_pt_t;

  logic clk, rst;
  pas_in_if #(.COORD_WIDTH(CW)) pt_in ();
  pas_out_if #(.COORD_WIDTH(CW)) pt_out ();

  polyline_area_simplifier dut (.clk(clk), .rst(rst), .pt_in(pt_in), .pt_out(pt_out));

  cmd_t cmd_q[$];
  kept_pt_t kept_q[$];
  int errors = 0;
  int cycle = 0;
  int stall_cnt = 0;
  int results_seen = 0;

  logic signed [CW-1:0] px[NPTS];
  logic signed [CW-1:0] py[NPTS];
  longint unsigned area[NPTS];
  int stamp[NPTS];
  int prv[NPTS];
  int nxt[NPTS];
  int n_loaded = 0;
  int n_left = 0;

  function automatic void refresh_area(int i);
    longint ax, ay, bx, by, cx, cy, cr;
    if (i == 0 || i + 1 >= n_loaded) begin
      area[i] = 0;
      return;
    end
    ax = px[prv[i]]; ay = py[prv[i]];
    bx = px[i]; by = py[i];
    cx = px[nxt[i]]; cy = py[nxt[i]];
    cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    area[i] = (cr < 0) ? -cr : cr;
  endfunction

  function automatic void relink();
    for (int i = 0; i < n_loaded; i++) begin
      stamp[i] = 0;
      prv[i] = (i == 0) ? 0 : i - 1;
      nxt[i] = (i + 1 < n_loaded) ? i + 1 : i;
    end
    for (int i = 0; i < n_loaded; i++) refresh_area(i);
    n_left = n_loaded;
  endfunction

  function automatic void simplify_and_emit(cmd_t c);
    int k, best, p, n, lastp, cnt;
    longint unsigned maxc;
    kept_pt_t e;
    if (c.op == pas_pkg::OP_LOAD) begin
      if (c.sn) n_loaded = 0;
      if (n_loaded < NPTS) begin
        px[n_loaded] = c.x;
        py[n_loaded] = c.y;
        n_loaded++;
        relink();
      end else if (c.sn) begin
        relink();
      end
      return;
    end
    k = (int'(c.tgt) < int'(pas_pkg::MIN_TARGET)) ? int'(pas_pkg::MIN_TARGET) : int'(c.tgt);
    while (n_left > k && n_loaded >= 3) begin
      lastp = n_loaded - 1;
      best = 0;
      for (int i = nxt[0]; i != lastp && i < n_loaded; i = nxt[i])
        if (best == 0 || area[best] > area[i]) best = i;
      if (best == 0) break;
      stamp[best] = n_left;
      p = prv[best];
      n = nxt[best];
      nxt[p] = n;
      prv[n] = p;
      n_left--;
      refresh_area(p);
      refresh_area(n);
    end
    maxc = 0;
    cnt = 0;
    for (int i = 0; i < n_loaded; i++)
      if (stamp[i] > k && area[i] > maxc) maxc = area[i];
    for (int i = 0; i < n_loaded; i++) begin
      if (stamp[i] <= k) begin
        e.x = px[i];
        e.y = py[i];
        e.last = 0;
        e.cost = maxc[KW-1:0];
        kept_q.insert(kept_q.size(), e);
        cnt++;
      end
    end
    if (cnt > 0) kept_q[kept_q.size() - 1].last = 1;
  endfunction

  function automatic cmd_t mk(pas_pkg::pas_op_t op, int sn, int x, int y, int t,
                              bit drain = 0);
    cmd_t c;
    c.op = op; c.sn = sn[0]; c.x = CW'(x); c.y = CW'(y); c.tgt = TW'(t); c.drain = drain;
    return c;
  endfunction

  function automatic void add_cmd(cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic bit quiet_stretch();
    return cycle > 4000 && cycle < 12000;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) cycle <= cycle + 1;

  always @(posedge clk) begin
    bit go;
    if (rst) begin
      pt_in.valid <= 0;
      pt_in.opcode <= pas_pkg::OP_LOAD;
      pt_in.start_new <= 0;
      pt_in.x_coord <= 0;
      pt_in.y_coord <= 0;
      pt_in.target_count <= 0;
    end else begin
      go = 1;
      if (pt_in.valid && pt_in.ready) begin
        simplify_and_emit(cmd_q.pop_front());
      end else if (pt_in.valid) begin
        go = 0;
      end
      if (go) begin
        if (cmd_q.size() > 0 && !(cmd_q[0].drain && kept_q.size() > 0) &&
            (quiet_stretch() || $urandom_range(99) >= 21)) begin
          pt_in.valid <= 1;
          pt_in.opcode <= cmd_q[0].op;
          pt_in.start_new <= cmd_q[0].sn;
          pt_in.x_coord <= cmd_q[0].x;
          pt_in.y_coord <= cmd_q[0].y;
          pt_in.target_count <= cmd_q[0].tgt;
        end else begin
          pt_in.valid <= 0;
        end
      end
    end
  end

  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    kept_pt_t e;
    if (rst) begin
      pt_out.ready <= 0;
    end else begin
      if (pt_out.valid && pt_out.ready) begin
        results_seen <= results_seen + 1;
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time, pt_out.out_x, pt_out.out_y);
          errors++;
        end else begin
          e = kept_q.pop_front();
          if (pt_out.out_x !== e.x || pt_out.out_y !== e.y || pt_out.last_point !== e.last ||
              pt_out.max_removed_cost !== e.cost) begin
            $display("%0t: mismatch expected x=%0d y=%0d last=%0b cost=%0d", $time,
                     e.x, e.y, e.last, e.cost);
            $display("%0t:          actual   x=%0d y=%0d last=%0b cost=%0d", $time,
                     pt_out.out_x, pt_out.out_y, pt_out.last_point, pt_out.max_removed_cost);
            errors++;
          end
        end
      end
      if (!hold_done && results_seen == 30) begin
        hold_done <= 1;
        hold_left <= 400;
        pt_out.ready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pt_out.ready <= 0;
      end else begin
        pt_out.ready <= quiet_stretch() || $urandom_range(99) >= 21;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("polyline_area_simplifier verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n, extra, nsimp, t, rng;
    // directed
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 3));
    add_cmd(mk(pas_pkg::OP_LOAD, 1, 5, -7, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 1, 0, 0, 0));
    add_cmd(mk(pas_pkg::OP_LOAD, 0, -32768, 32767, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 1));
    add_cmd(mk(pas_pkg::OP_LOAD, 0, 32767, -32768, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 64));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 1, 0, 0, 127));
    add_cmd(mk(pas_pkg::OP_LOAD, 1, -32768, -32768, 0, 1));
    add_cmd(mk(pas_pkg::OP_LOAD, 0, 32767, 32767, 0));
    add_cmd(mk(pas_pkg::OP_LOAD, 0, -32768, 32767, 0));
    add_cmd(mk(pas_pkg::OP_LOAD, 0, 32767, -32768, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 2));
    add_cmd(mk(pas_pkg::OP_LOAD, 1, 0, 0, 0));
    for (int i = 1; i < 6; i++) add_cmd(mk(pas_pkg::OP_LOAD, 0, i, (i % 2) * 3, 0));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 4));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 3));
    add_cmd(mk(pas_pkg::OP_SIMPLIFY, 0, 0, 0, 6));
    // random polylines
    while (cmd_q.size() < 370) begin
      if ($urandom_range(7) == 0) begin
        n = NPTS;
        extra = $urandom_range(3);
      end else begin
        n = $urandom_range(10, 1);
        extra = 0;
      end
      rng = ($urandom_range(2) == 0) ? 32767 : $urandom_range(200, 2);
      for (int i = 0; i < n + extra; i++) begin
        add_cmd(mk(pas_pkg::OP_LOAD, (i == 0) || (i >= n && $urandom_range(4) == 0),
                   $urandom_range(2 * rng, 0) - rng, $urandom_range(2 * rng, 0) - rng,
                   $urandom_range(127), i == 0 && $urandom_range(5) == 0));
        if ($urandom_range(29) == 0)
          add_cmd(mk(pas_pkg::OP_SIMPLIFY, $urandom, 0, 0, $urandom_range(n + 1)));
      end
      nsimp = $urandom_range(3, 1);
      for (int s = 0; s < nsimp; s++) begin
        t = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(n + 1);
        add_cmd(mk(pas_pkg::OP_SIMPLIFY, $urandom, $urandom, $urandom, t));
      end
    end
    wait (!rst);
    wait (cmd_q.size() == 0 && !pt_in.valid && kept_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && kept_q.size() == 0) begin
      $display("polyline_area_simplifier verification clean");
    end else begin
      $display("polyline_area_simplifier verification failed");
    end
    $finish;
  end
endmodule

/* polyline_area_simplifier.f */
+incdir+sv
sv/pas_pkg.sv
sv/pas_in_if.sv
sv/pas_out_if.sv
sv/pas_area.sv
sv/pas_store.sv
sv/polyline_area_simplifier.sv
tb/sv/polyline_area_simplifier_tb.sv
